// ===== hw/rtl/grcl_pkg.sv =====
// ----------------------------------------------------------------------------
// grcl_pkg
// Shared types, codes and constants of the gradient ramp color lookup unit.
// ----------------------------------------------------------------------------
package grcl_pkg;

	localparam int MAX_STOPS_DEF = 16;
	localparam int POS_BITS_DEF  = 16;

	// Interpolation weight: 16-bit fraction, all ones is 1.0
	localparam int          T_BITS = 16;
	localparam logic [15:0] T_ONE  = 16'hFFFF;
	localparam logic [15:0] T_HALF = 16'h7FFF;

	// Weight divider: quotient bits resolved per pipeline stage
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = T_BITS / DIV_STEPS;

	localparam int          CNT_REG_W      = 5;
	localparam logic [4:0]  STOP_COUNT_RST = 5'd2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL  = 1'b1;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	localparam rgba_t BLACK = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

	// Per-query side information that travels alongside the weight datapath
	typedef struct packed {
		rgba_t lo;
		rgba_t hi;
		logic  black;   // no valid stops
		logic  zero_t;  // weight forced to 0.0
		logic  full_t;  // weight saturates at 1.0
	} side_t;

endpackage

// ===== hw/rtl/grcl_stop_table.sv =====
// ----------------------------------------------------------------------------
// grcl_stop_table
// Stop storage, bracket search and two-port registered read of the stop pair.
// ----------------------------------------------------------------------------
module grcl_stop_table #(
	parameter int MAX_STOPS = grcl_pkg::MAX_STOPS_DEF,
	parameter int POS_BITS  = grcl_pkg::POS_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            vld_s1,
	input  logic                            func_s1,
	input  logic [3:0]                      slot_s1,
	input  logic [POS_BITS-1:0]             wpos_s1,
	input  grcl_pkg::rgba_t                 wrgba_s1,
	input  logic [POS_BITS-1:0]             q_s1,
	input  logic [grcl_pkg::CNT_REG_W-1:0]  stop_count,
	output logic                            vld_s2,
	output logic [POS_BITS-1:0]             q_s2,
	output logic [POS_BITS-1:0]             plo_s2,
	output logic [POS_BITS-1:0]             phi_s2,
	output grcl_pkg::side_t                 side_s2
);

	localparam int IDX_W = $clog2(MAX_STOPS);
	localparam int CNT_W = $clog2(MAX_STOPS + 1);
	localparam int ENT_W = POS_BITS + 32;

	logic [POS_BITS-1:0] pos_arr [MAX_STOPS];
	logic [ENT_W-1:0]    mem [MAX_STOPS];
	logic [ENT_W-1:0]    rd_lo_s2;
	logic [ENT_W-1:0]    rd_hi_s2;
	logic                black_s2;

	logic [CNT_W-1:0]     n;
	logic [MAX_STOPS-2:0] hit;
	logic                 found;
	logic [IDX_W-1:0]     first;
	logic [IDX_W-1:0]     lo_idx;
	logic [IDX_W-1:0]     hi_idx;
	logic                 wr_en;
	logic                 eval;
	logic [IDX_W-1:0]     wslot;

	assign wr_en = vld_s1 && (func_s1 == grcl_pkg::FUNC_WRITE) && (32'(slot_s1) < MAX_STOPS);
	assign eval  = vld_s1 && (func_s1 == grcl_pkg::FUNC_EVAL);
	assign wslot = IDX_W'(slot_s1);

	// Counts beyond the table act as a full table
	assign n = (32'(stop_count) > MAX_STOPS) ? CNT_W'(MAX_STOPS) : CNT_W'(stop_count);

	always_comb begin
		for (int i = 0; i < MAX_STOPS - 1; i++) begin
			hit[i] = (32'(i) + 2 <= 32'(n)) && (pos_arr[i] <= q_s1) && (pos_arr[i + 1] >= q_s1);
		end
	end

	// First bracketing pair wins
	always_comb begin
		found = 1'b0;
		first = '0;
		for (int i = 0; i < MAX_STOPS - 1; i++) begin
			if (!found && hit[i]) begin
				found = 1'b1;
				first = IDX_W'(i);
			end
		end
	end

	always_comb begin
		if (n <= CNT_W'(1)) begin
			lo_idx = '0;
			hi_idx = '0;
		end else if (found) begin
			lo_idx = first;
			hi_idx = first + IDX_W'(1);
		end else begin
			lo_idx = '0;
			hi_idx = IDX_W'(n - CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_arr[wslot] <= wpos_s1;
			mem[wslot]     <= {wpos_s1, wrgba_s1};
		end
		rd_lo_s2 <= mem[lo_idx];
		rd_hi_s2 <= mem[hi_idx];
		q_s2     <= q_s1;
		black_s2 <= (n == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= eval;
		end
	end

	assign plo_s2         = rd_lo_s2[ENT_W-1:32];
	assign phi_s2         = rd_hi_s2[ENT_W-1:32];
	assign side_s2.lo     = grcl_pkg::rgba_t'(rd_lo_s2[31:0]);
	assign side_s2.hi     = grcl_pkg::rgba_t'(rd_hi_s2[31:0]);
	assign side_s2.black  = black_s2;
	assign side_s2.zero_t = 1'b0;
	assign side_s2.full_t = 1'b0;

endmodule

// ===== hw/rtl/grcl_div_stage.sv =====
// ----------------------------------------------------------------------------
// grcl_div_stage
// One registered slice of the restoring weight divider.
// ----------------------------------------------------------------------------
module grcl_div_stage #(
	parameter int POS_BITS = grcl_pkg::POS_BITS_DEF,
	parameter int STEPS    = grcl_pkg::DIV_STEPS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 vld_i,
	input  logic [POS_BITS+grcl_pkg::T_BITS-1:0] w_i,
	input  logic [POS_BITS-1:0]                  dv_i,
	output logic                                 vld_o,
	output logic [POS_BITS+grcl_pkg::T_BITS-1:0] w_o,
	output logic [POS_BITS-1:0]                  dv_o
);

	localparam int TB = grcl_pkg::T_BITS;
	localparam int WW = POS_BITS + TB;

	logic [WW-1:0]       w_nxt;
	logic [POS_BITS:0]   top;
	logic                qb;
	logic                vld_s1;
	logic [WW-1:0]       w_s1;
	logic [POS_BITS-1:0] dv_s1;

	// Work word: remainder in the upper bits, dividend bits shift out of the
	// lower half while quotient bits shift in.
	always_comb begin
		w_nxt = w_i;
		top   = '0;
		qb    = 1'b0;
		for (int s = 0; s < STEPS; s++) begin
			top = {w_nxt[WW-1:TB], w_nxt[TB-1]};
			qb  = (top >= {1'b0, dv_i});
			if (qb) begin
				top = top - {1'b0, dv_i};
			end
			w_nxt = {top[POS_BITS-1:0], w_nxt[TB-2:0], qb};
		end
	end

	always_ff @(posedge clk) begin
		w_s1  <= w_nxt;
		dv_s1 <= dv_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
		end
	end

	assign vld_o = vld_s1;
	assign w_o   = w_s1;
	assign dv_o  = dv_s1;

endmodule

// ===== hw/rtl/grcl_blend.sv =====
// ----------------------------------------------------------------------------
// grcl_blend
// Weight select, per-channel products and rounding divide by 65535.
// ----------------------------------------------------------------------------
module grcl_blend (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vld_i,
	input  logic [grcl_pkg::T_BITS-1:0]       quo_i,
	input  grcl_pkg::side_t                   side_i,
	output logic                              vld_o,
	output grcl_pkg::rgba_t                   rgba_o
);

	localparam int TB = grcl_pkg::T_BITS;
	localparam int PW = TB + 8;

	logic [TB-1:0] t;
	logic [TB-1:0] t_inv;
	logic [7:0]    clo [4];
	logic [7:0]    chi [4];

	logic          vld_s10;
	logic          black_s10;
	logic [PW-1:0] pl_s10 [4];
	logic [PW-1:0] ph_s10 [4];

	logic [PW:0]   x   [4];
	logic [8:0]    q0  [4];
	logic [TB:0]   r   [4];
	logic [7:0]    res [4];

	logic            vld_s11;
	grcl_pkg::rgba_t rgba_s11;

	always_comb begin
		if (side_i.zero_t) begin
			t = '0;
		end else if (side_i.full_t) begin
			t = grcl_pkg::T_ONE;
		end else begin
			t = quo_i;
		end
		t_inv = grcl_pkg::T_ONE - t;
	end

	assign clo[0] = side_i.lo.r;
	assign clo[1] = side_i.lo.g;
	assign clo[2] = side_i.lo.b;
	assign clo[3] = side_i.lo.a;
	assign chi[0] = side_i.hi.r;
	assign chi[1] = side_i.hi.g;
	assign chi[2] = side_i.hi.b;
	assign chi[3] = side_i.hi.a;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			pl_s10[k] <= PW'(clo[k]) * PW'(t_inv);
			ph_s10[k] <= PW'(chi[k]) * PW'(t);
		end
		black_s10 <= side_i.black;
	end

	// floor(x / 65535) as x>>16 plus one correction step
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			x[k]   = (PW + 1)'(pl_s10[k]) + (PW + 1)'(ph_s10[k]) + (PW + 1)'(grcl_pkg::T_HALF);
			q0[k]  = x[k][PW:TB];
			r[k]   = (TB + 1)'(x[k][TB-1:0]) + (TB + 1)'(q0[k]);
			res[k] = 8'(q0[k] + ((r[k] >= (TB + 1)'(grcl_pkg::T_ONE)) ? 9'd1 : 9'd0));
		end
	end

	always_ff @(posedge clk) begin
		if (black_s10) begin
			rgba_s11 <= grcl_pkg::BLACK;
		end else begin
			rgba_s11.r <= res[0];
			rgba_s11.g <= res[1];
			rgba_s11.b <= res[2];
			rgba_s11.a <= res[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s10 <= vld_i;
			vld_s11 <= vld_s10;
		end
	end

	assign vld_o  = vld_s11;
	assign rgba_o = rgba_s11;

endmodule

// ===== hw/rtl/gradient_ramp_color_lookup_unit.sv =====
// Pipeline: a query passes eleven register stages from acceptance to the done strobe;
//   stop writes give no result.
// Throughput: one transaction per cycle, set by the register pipeline; busy stays low.
// The receiver cannot stall; every result is on the ports for exactly one cycle.
// Reset: clears the valid bits and sets stop_count to 2; the stop table is
//   not cleared and holds nothing meaningful until written.
// ----------------------------------------------------------------------------
// gradient_ramp_color_lookup_unit
// Multi-stop linear gradient lookup: RGBA color for a query position.
// ----------------------------------------------------------------------------
module gradient_ramp_color_lookup_unit #(
	parameter int MAX_STOPS = grcl_pkg::MAX_STOPS_DEF,
	parameter int POS_BITS  = grcl_pkg::POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [3:0]  stop_slot,
	input  logic [15:0] stop_position,
	input  logic [7:0]  stop_red,
	input  logic [7:0]  stop_green,
	input  logic [7:0]  stop_blue,
	input  logic [7:0]  stop_alpha,
	input  logic [15:0] query_position,
	// stop_count register
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	// result channel
	output logic        done,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha
);

	localparam int TB = grcl_pkg::T_BITS;
	localparam int WW = POS_BITS + TB;
	localparam int NS = grcl_pkg::DIV_STAGES;

	// stop_count register; the user must write it only while the pipeline is drained, the block leaves it unchecked
	logic [grcl_pkg::CNT_REG_W-1:0] stop_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= grcl_pkg::STOP_COUNT_RST;
		end else if (cfg_we) begin
			stop_count_q <= cfg_wdata;
		end
	end

	// Every stage advances each cycle and nothing downstream can push back,
	// so a new command is always taken.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: capture the command. Positions keep their low POS_BITS bits.
	// ------------------------------------------------------------------
	logic                vld_s1;
	logic                func_s1;
	logic [3:0]          slot_s1;
	logic [POS_BITS-1:0] wpos_s1;
	grcl_pkg::rgba_t     wrgba_s1;
	logic [POS_BITS-1:0] q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		func_s1    <= func;
		slot_s1    <= stop_slot;
		wpos_s1    <= POS_BITS'(stop_position);
		wrgba_s1.r <= stop_red;
		wrgba_s1.g <= stop_green;
		wrgba_s1.b <= stop_blue;
		wrgba_s1.a <= stop_alpha;
		q_s1       <= POS_BITS'(query_position);
	end

	// ------------------------------------------------------------------
	// Stage 2: stop writes commit here, in command order; queries search
	// for their bracketing pair and read both stops from the table.
	// Only queries travel past this point.
	// ------------------------------------------------------------------
	logic                vld_s2;
	logic [POS_BITS-1:0] q_s2;
	logic [POS_BITS-1:0] plo_s2;
	logic [POS_BITS-1:0] phi_s2;
	grcl_pkg::side_t     side_s2;

	grcl_stop_table #(
		.MAX_STOPS (MAX_STOPS),
		.POS_BITS  (POS_BITS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_s1     (vld_s1),
		.func_s1    (func_s1),
		.slot_s1    (slot_s1),
		.wpos_s1    (wpos_s1),
		.wrgba_s1   (wrgba_s1),
		.q_s1       (q_s1),
		.stop_count (stop_count_q),
		.vld_s2     (vld_s2),
		.q_s2       (q_s2),
		.plo_s2     (plo_s2),
		.phi_s2     (phi_s2),
		.side_s2    (side_s2)
	);

	// ------------------------------------------------------------------
	// Stage 3: signed offset of the query and signed span of the pair.
	// ------------------------------------------------------------------
	logic                       vld_s3;
	logic signed [POS_BITS:0]   diff_s3;
	logic signed [POS_BITS:0]   span_s3;
	grcl_pkg::side_t            side_s3;

	always_ff @(posedge clk) begin
		diff_s3 <= $signed({1'b0, q_s2}) - $signed({1'b0, plo_s2});
		span_s3 <= $signed({1'b0, phi_s2}) - $signed({1'b0, plo_s2});
		side_s3 <= side_s2;
	end

	// ------------------------------------------------------------------
	// Stage 4: magnitudes, and the cases that pin the weight to 0.0:
	// query on the lower stop, zero span, or offset against the span.
	// A zero weight also yields the lower color exactly, which covers
	// the single-stop case.
	// ------------------------------------------------------------------
	logic                vld_s4;
	logic [POS_BITS-1:0] ad_s4;
	logic [POS_BITS-1:0] as_s4;
	grcl_pkg::side_t     side_s4;
	logic [POS_BITS-1:0] diff_mag;
	logic [POS_BITS-1:0] span_mag;
	logic                zero_t;
	grcl_pkg::side_t     side_zt;

	always_comb begin
		diff_mag = diff_s3[POS_BITS] ? POS_BITS'(-diff_s3) : POS_BITS'(diff_s3);
		span_mag = span_s3[POS_BITS] ? POS_BITS'(-span_s3) : POS_BITS'(span_s3);
		zero_t   = (diff_s3 == '0) || (span_s3 == '0) || (diff_s3[POS_BITS] != span_s3[POS_BITS]);
		side_zt        = side_s3;
		side_zt.zero_t = zero_t;
	end

	always_ff @(posedge clk) begin
		ad_s4   <= diff_mag;
		as_s4   <= span_mag;
		side_s4 <= side_zt;
	end

	// ------------------------------------------------------------------
	// Stage 5: saturation check and the rounded dividend
	// ad * 65535 + span/2, ready for the divider.
	// ------------------------------------------------------------------
	logic                vld_s5;
	logic [WW-1:0]       w_s5;
	logic [POS_BITS-1:0] dv_s5;
	grcl_pkg::side_t     side_s5;
	grcl_pkg::side_t     side_ft;

	always_comb begin
		side_ft        = side_s4;
		side_ft.full_t = (ad_s4 >= as_s4);
	end

	always_ff @(posedge clk) begin
		w_s5    <= (WW'(ad_s4) << TB) - WW'(ad_s4) + WW'(as_s4 >> 1);
		dv_s5   <= as_s4;
		side_s5 <= side_ft;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stages 6 to 9: restoring divider, a few quotient bits per stage.
	// The side information rides in a matching delay line.
	// ------------------------------------------------------------------
	logic                dvld [NS+1];
	logic [WW-1:0]       dw   [NS+1];
	logic [POS_BITS-1:0] ddv  [NS+1];
	grcl_pkg::side_t     side_sd [NS];

	assign dvld[0] = vld_s5;
	assign dw[0]   = w_s5;
	assign ddv[0]  = dv_s5;

	for (genvar g = 0; g < NS; g++) begin : g_div
		grcl_div_stage #(
			.POS_BITS (POS_BITS),
			.STEPS    (grcl_pkg::DIV_STEPS)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (dvld[g]),
			.w_i    (dw[g]),
			.dv_i   (ddv[g]),
			.vld_o  (dvld[g+1]),
			.w_o    (dw[g+1]),
			.dv_o   (ddv[g+1])
		);
	end

	always_ff @(posedge clk) begin
		side_sd[0] <= side_s5;
		for (int k = 1; k < NS; k++) begin
			side_sd[k] <= side_sd[k-1];
		end
	end

	// ------------------------------------------------------------------
	// Stages 10 and 11: pick the weight, blend the four channels, round.
	// ------------------------------------------------------------------
	grcl_pkg::rgba_t rgba;

	grcl_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (dvld[NS]),
		.quo_i  (dw[NS][TB-1:0]),
		.side_i (side_sd[NS-1]),
		.vld_o  (done),
		.rgba_o (rgba)
	);

	assign out_red   = rgba.r;
	assign out_green = rgba.g;
	assign out_blue  = rgba.b;
	assign out_alpha = rgba.a;

endmodule

// ===== sim/gradient_ramp_color_lookup_unit_tb.sv =====
// ----------------------------------------------------------------------------
// gradient_ramp_color_lookup_unit_tb
// Drives stop writes, color queries and stop_count changes into the gradient
// lookup. A short directed table runs first, then random gradients. Every
// color that comes out is compared per channel with a pinned color or an in-bench predictor.
// ----------------------------------------------------------------------------
module gradient_ramp_color_lookup_unit_tb;

	import grcl_pkg::*;

	// Pipeline depth from acceptance to done, plus margin for settling
	localparam int LATENCY      = 11;
	localparam int DRAIN_CYCLES = LATENCY + 4;
	localparam int TARGET_ITEMS = 1450;

	typedef enum logic {ROW_ITEM, ROW_SET_COUNT} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        func;
		logic [3:0]  slot;
		logic [15:0] pos;
		rgba_t       col;
		logic [15:0] query;
		logic        pinned;   // expected color typed into the table
		rgba_t       want;
		logic [4:0]  count;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [3:0]  stop_slot;
	logic [15:0] stop_position;
	logic [7:0]  stop_red;
	logic [7:0]  stop_green;
	logic [7:0]  stop_blue;
	logic [7:0]  stop_alpha;
	logic [15:0] query_position;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        done;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [7:0]  out_alpha;

	// Pinned expectation travels with the transaction it belongs to
	logic        pin_valid;
	rgba_t       pin_color;

	// Predictor copy of the stop table and the count register
	logic [15:0] ramp_pos [MAX_STOPS_DEF];
	rgba_t       ramp_col [MAX_STOPS_DEF];
	logic [4:0]  ramp_count;

	rgba_t       pending_colors[$];
	int          mismatch_count = 0;
	int          items_sent = 0;
	bit          no_idle = 1'b0;

	gradient_ramp_color_lookup_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.stop_slot      (stop_slot),
		.stop_position  (stop_position),
		.stop_red       (stop_red),
		.stop_green     (stop_green),
		.stop_blue      (stop_blue),
		.stop_alpha     (stop_alpha),
		.query_position (query_position),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.out_red        (out_red),
		.out_green      (out_green),
		.out_blue       (out_blue),
		.out_alpha      (out_alpha)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or loses results
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Blend one channel with rounding to nearest; w is a 16-bit weight
	function automatic logic [7:0] mix(logic [7:0] a, logic [7:0] b, logic [15:0] w);
		longint num;
		num = longint'(a) * (longint'(T_ONE) - longint'(w)) + longint'(b) * longint'(w)
			+ longint'(T_HALF);
		return 8'(num / longint'(T_ONE));
	endfunction

	// Color that the gradient gives at position q, from the current table
	function automatic rgba_t ramp_color(logic [15:0] q);
		int          n;
		int          lo;
		int          hi;
		bit          found;
		longint      diff;
		longint      span;
		longint      mag_d;
		longint      mag_s;
		logic [15:0] w;
		rgba_t       c;
		n = (ramp_count > MAX_STOPS_DEF) ? MAX_STOPS_DEF : int'(ramp_count);
		if (n == 0)
			return BLACK;
		if (n == 1)
			return ramp_col[0];
		// First bracketing pair wins; fall back to the outer stops
		lo = 0;
		hi = n - 1;
		found = 1'b0;
		for (int i = 0; i + 1 < n; i++) begin
			if (!found && ramp_pos[i] <= q && ramp_pos[i + 1] >= q) begin
				lo = i;
				hi = i + 1;
				found = 1'b1;
			end
		end
		if (ramp_pos[lo] == ramp_pos[hi])
			return ramp_col[lo];
		diff = longint'(q) - longint'(ramp_pos[lo]);
		span = longint'(ramp_pos[hi]) - longint'(ramp_pos[lo]);
		// Clamp the weight: zero on opposite signs, one past the far stop
		if (diff == 0 || ((diff < 0) != (span < 0))) begin
			w = '0;
		end else begin
			mag_d = (diff < 0) ? -diff : diff;
			mag_s = (span < 0) ? -span : span;
			if (mag_d >= mag_s)
				w = T_ONE;
			else
				w = 16'((mag_d * longint'(T_ONE) + mag_s / 2) / mag_s);
		end
		c.r = mix(ramp_col[lo].r, ramp_col[hi].r, w);
		c.g = mix(ramp_col[lo].g, ramp_col[hi].g, w);
		c.b = mix(ramp_col[lo].b, ramp_col[hi].b, w);
		c.a = mix(ramp_col[lo].a, ramp_col[hi].a, w);
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_chan(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %02h, expected %02h", name, got, want));
	endtask

	// Sample everything at the rising edge: values seen here are the ones
	// that the edge captures, so acceptance and results line up exactly.
	always @(posedge clk) begin : monitor
		rgba_t want;
		if (!arst_n) begin
			ramp_count = STOP_COUNT_RST;
		end else begin
			// Compare a result against the oldest pending color
			if (done) begin
				if (pending_colors.size() == 0) begin
					report_mismatch("result strobe with no query pending");
				end else begin
					want = pending_colors.pop_front();
					check_chan("red",   out_red,   want.r);
					check_chan("green", out_green, want.g);
					check_chan("blue",  out_blue,  want.b);
					check_chan("alpha", out_alpha, want.a);
				end
			end
			if (cfg_we)
				ramp_count = cfg_wdata;
			// Track each accepted transaction in program order
			if (start && !busy) begin
				if (func == FUNC_WRITE) begin
					ramp_pos[stop_slot] = stop_position;
					ramp_col[stop_slot] = {stop_red, stop_green, stop_blue, stop_alpha};
				end else begin
					pending_colors.push_back(pin_valid ? pin_color : ramp_color(query_position));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_chan();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	function automatic rgba_t rand_color();
		rgba_t c;
		c.r = rand_chan();
		c.g = rand_chan();
		c.b = rand_chan();
		c.a = rand_chan();
		return c;
	endfunction

	// Query position: often inside the ramp, some on or beside the stops, the rest wild
	function automatic logic [15:0] pick_query();
		int r;
		int last;
		int lo_p;
		int hi_p;
		r = $urandom_range(0, 99);
		last = (ramp_count > MAX_STOPS_DEF) ? MAX_STOPS_DEF - 1 :
			(ramp_count == 0) ? 0 : int'(ramp_count) - 1;
		lo_p = ramp_pos[0];
		hi_p = ramp_pos[last];
		if (r < 40)
			return (lo_p <= hi_p) ? 16'($urandom_range(hi_p, lo_p))
				: 16'($urandom_range(lo_p, hi_p));
		if (r < 60)
			return ramp_pos[$urandom_range(0, last)] + 16'($urandom_range(0, 2)) - 16'd1;
		if (r < 85)
			return 16'($urandom);
		return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
	endfunction

	// Present one transaction, hold it until accepted, then sometimes idle a while
	task automatic send(logic f, logic [3:0] s, logic [15:0] p, rgba_t c,
			logic [15:0] qp, logic pin, rgba_t want);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		start          <= 1'b1;
		func           <= f;
		stop_slot      <= s;
		stop_position  <= p;
		stop_red       <= c.r;
		stop_green     <= c.g;
		stop_blue      <= c.b;
		stop_alpha     <= c.a;
		query_position <= qp;
		pin_valid      <= pin;
		pin_color      <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Unused fields carry noise so every input bit toggles
	task automatic send_stop(logic [3:0] s, logic [15:0] p, rgba_t c);
		send(FUNC_WRITE, s, p, c, 16'($urandom), 1'b0, BLACK);
	endtask

	task automatic send_query(logic [15:0] qp);
		send(FUNC_EVAL, 4'($urandom), 16'($urandom), rgba_t'($urandom), qp, 1'b0, BLACK);
	endtask

	// Change stop_count only with the pipeline drained
	task automatic set_count(logic [4:0] n);
		start <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Rewrite all slots with ascending positions; zero strides make flat spans
	task automatic write_sorted_table();
		int run;
		int stride;
		run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16'h2000);
		case ($urandom_range(0, 3))
			0: stride = 0;
			1: stride = 16'h40;
			2: stride = 16'h1000;
			default: stride = 16'h2400;
		endcase
		for (int s = 0; s < MAX_STOPS_DEF; s++) begin
			send_stop(4'(s), (run > 65535) ? 16'hFFFF : 16'(run), rand_color());
			if (stride > 0 && $urandom_range(0, 4) != 0)
				run = run + $urandom_range(1, stride);
		end
	endtask

	function automatic row_t stop_row(logic [3:0] s, logic [15:0] p, rgba_t c);
		row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.func = FUNC_WRITE;
		r.slot = s;
		r.pos  = p;
		r.col  = c;
		return r;
	endfunction

	function automatic row_t query_row(logic [15:0] qp, logic pin, rgba_t want);
		row_t r;
		r = '0;
		r.kind   = ROW_ITEM;
		r.func   = FUNC_EVAL;
		r.query  = qp;
		r.pinned = pin;
		r.want   = want;
		return r;
	endfunction

	function automatic row_t count_row(logic [4:0] n);
		row_t r;
		r = '0;
		r.kind  = ROW_SET_COUNT;
		r.count = n;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		row_t plan[$];
		int   phase;
		int   nq;
		int   r;
		logic [4:0] n;

		// Known values on every input before the first edge
		arst_n         = 1'b0;
		start          = 1'b0;
		func           = FUNC_WRITE;
		stop_slot      = '0;
		stop_position  = '0;
		stop_red       = '0;
		stop_green     = '0;
		stop_blue      = '0;
		stop_alpha     = '0;
		query_position = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		pin_valid      = 1'b0;
		pin_color      = BLACK;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Pinned colors are the ones obvious by inspection.
		// Two stops under the reset count, ends of the ramp
		plan.push_back(stop_row(4'd0, 16'h0000, 32'hFF0000FF));
		plan.push_back(stop_row(4'd1, 16'hFFFF, 32'h00FF0080));
		plan.push_back(query_row(16'h0000, 1'b1, 32'hFF0000FF));
		plan.push_back(query_row(16'hFFFF, 1'b1, 32'h00FF0080));
		plan.push_back(query_row(16'h8000, 1'b0, BLACK));
		plan.push_back(query_row(16'h0001, 1'b0, BLACK));
		// Empty table gives opaque black
		plan.push_back(count_row(5'd0));
		plan.push_back(query_row(16'h1234, 1'b1, BLACK));
		// Single stop returns slot 0 regardless of position
		plan.push_back(count_row(5'd1));
		plan.push_back(query_row(16'hFFFF, 1'b1, 32'hFF0000FF));
		// Full-swing channels around the midpoint exercise rounding
		plan.push_back(count_row(5'd2));
		plan.push_back(stop_row(4'd0, 16'h0000, 32'h00000000));
		plan.push_back(stop_row(4'd1, 16'hFFFF, 32'hFFFFFFFF));
		plan.push_back(query_row(16'h7FFF, 1'b0, BLACK));
		plan.push_back(query_row(16'h8000, 1'b0, BLACK));
		plan.push_back(stop_row(4'd15, 16'hFFFF, 32'hFFFFFFFF));
		// Coincident stops: zero span returns the lower color
		plan.push_back(stop_row(4'd0, 16'h4000, 32'hAABBCCDD));
		plan.push_back(stop_row(4'd1, 16'h4000, 32'h11223344));
		plan.push_back(query_row(16'h4000, 1'b1, 32'hAABBCCDD));
		plan.push_back(query_row(16'h0100, 1'b1, 32'hAABBCCDD));
		// Descending stops: weight clamps on both sides
		plan.push_back(stop_row(4'd2, 16'h2000, 32'h55667788));
		plan.push_back(count_row(5'd3));
		plan.push_back(query_row(16'h3000, 1'b0, BLACK));
		plan.push_back(query_row(16'hC000, 1'b0, BLACK));
		plan.push_back(query_row(16'h0000, 1'b0, BLACK));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SET_COUNT)
				set_count(plan[i].count);
			else
				send(plan[i].func, plan[i].slot, plan[i].pos, plan[i].col,
					plan[i].query, plan[i].pinned, plan[i].want);
		end

		// Fill every slot so any count can be read safely from here on
		write_sorted_table();

		// Random phases: new count, usually a fresh sorted ramp, then queries
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			if (phase == 0)
				n = 5'd31;
			else if (phase == 1)
				n = 5'd16;
			else begin
				r = $urandom_range(0, 11);
				case (r)
					0: n = 5'd0;
					1: n = 5'd1;
					2: n = 5'd2;
					3, 4: n = 5'd16;
					5: n = 5'($urandom_range(17, 31));
					default: n = 5'($urandom_range(2, 16));
				endcase
			end
			set_count(n);
			no_idle = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			if (r < 7) begin
				write_sorted_table();
			end else if (r == 7) begin
				// Scramble a few slots: unsorted ramps
				repeat ($urandom_range(1, 4))
					send_stop(4'($urandom), 16'($urandom), rand_color());
			end
			nq = $urandom_range(8, 40);
			repeat (nq) begin
				r = $urandom_range(0, 99);
				if (r < 85)
					send_query(pick_query());
				else if (r < 95)
					send_stop(4'($urandom), 16'($urandom), rand_color());
				else
					send_stop(4'($urandom), ramp_pos[$urandom_range(0, 15)], rand_color());
			end
			phase++;
		end

		// Drain: let every pending color arrive, then watch for strays
		start <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/grcl_pkg.sv
hw/rtl/grcl_stop_table.sv
hw/rtl/grcl_div_stage.sv
hw/rtl/grcl_blend.sv
hw/rtl/gradient_ramp_color_lookup_unit.sv
sim/gradient_ramp_color_lookup_unit_tb.sv
